// ===== hdl/asrs_pkg.sv =====
// Shared constants for the affine scale / rotation split block.
`default_nettype none
package asrs_pkg;
  localparam int NUM_COL    = 3;
  localparam int COL_W      = 2;
  localparam int FIELD_W    = 32;
  localparam int SCALE_W    = 31;
  localparam int ROT_W      = 18;
  localparam int NUM_IN     = 12;
  localparam int S_TDATA_W  = NUM_IN * FIELD_W;
  localparam int M_TDATA_W  = 120;
  localparam logic [COL_W-1:0] LAST_COL = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/affine_scale_rotation_split.sv =====
// Top level: splits a 3x4 affine matrix into per-column scale, rotation and translation.
// Takes one 3x4 Q-format matrix per request and returns three result requests, one
// per column 0, 1, 2 in order, tlast on column 2. Each result carries the column
// length (floor of the square root of the sum of squares, saturated at 0x7FFFFFFF),
// the column divided by that length (truncated toward zero; identity column when the
// length is zero) and the translation entry of the matching row. One column enters
// the pipeline per cycle while it advances, and a new matrix is taken when idle or
// as the last column of the one before enters; the three columns pass in turn through
// the single shared root/divide pipeline. That pipeline is made of one serializer
// stage, a square stage, a sum stage, DATA_WIDTH root stages (one root bit each) and
// FRAC_BITS+1 divide stages (one quotient bit each, three lanes). The whole
// pipeline holds when the result is not taken; nothing is lost or repeated.
`default_nettype none
module affine_scale_rotation_split #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23, 32 bits each, from bit 0 up
  input  wire logic [asrs_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // column[1:0] col_scale[32:2] rot_r0[50:33] rot_r1[68:51] rot_r2[86:69]
  // trans_part[118:87], bit 119 zero
  output logic [asrs_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tlast
);

  localparam int W     = DATA_WIDTH;
  localparam int SQ_W  = 2 * DATA_WIDTH;
  localparam int QW    = FRAC_BITS + 1;
  localparam int K_SQ  = 1;
  localparam int K_SUM = 2;
  localparam int K_RT0 = 3;
  localparam int K_DV0 = K_RT0 + DATA_WIDTH;
  localparam int NSTG  = K_DV0 + FRAC_BITS + 1;
  localparam int LST   = NSTG - 1;

  typedef struct packed {
    logic [asrs_pkg::COL_W-1:0]   col;
    logic                         last;
    logic [asrs_pkg::FIELD_W-1:0] trans;
    logic [2:0]                   neg;
    logic [2:0][W-1:0]            mag;
    logic [2:0][SQ_W-1:0]         sq;
    logic [SQ_W-1:0]              rad;   // radicand, consumed two bits per root step
    logic [W+1:0]                 srem;  // root partial remainder
    logic [W-1:0]                 root;
    logic [2:0][W-1:0]            drem;  // divide partial remainders
    logic [2:0][QW-1:0]           quo;
  } stage_t;

  // Input buffer and column serializer
  logic [asrs_pkg::NUM_IN-1:0][asrs_pkg::FIELD_W-1:0] mat;
  logic                              busy;
  logic [asrs_pkg::COL_W-1:0]        ccnt;
  logic                              adv;

  stage_t          st  [NSTG];
  stage_t          nxt [NSTG];
  logic [NSTG-1:0] vld;

  // Advance whenever the output register is empty or its request is taken.
  assign adv      = !vld[LST] || m_tready;
  assign s_tready = !busy || (adv && ccnt == asrs_pkg::LAST_COL);

  // A new matrix restarts the column count; otherwise advance one column per move.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ccnt <= '0;
    end else if (s_tvalid && s_tready) begin
      busy <= 1'b1;
      ccnt <= '0;
    end else if (adv && busy) begin
      if (ccnt == asrs_pkg::LAST_COL) begin
        busy <= 1'b0;
        ccnt <= '0;
      end else begin
        ccnt <= ccnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mat <= s_tdata;
    end
  end

  // Stage 0: pick the current column and its translation entry, take magnitudes and signs.
  always_comb begin
    logic [asrs_pkg::FIELD_W-1:0] e;
    logic signed [W-1:0]          ev;
    logic signed [W-1:0]          tv;
    nxt[0]      = '0;
    nxt[0].col  = ccnt;
    nxt[0].last = (ccnt == asrs_pkg::LAST_COL);
    for (int r = 0; r < 3; r++) begin
      case (ccnt)
        2'd0:    e = mat[r*4 + 0];
        2'd1:    e = mat[r*4 + 1];
        default: e = mat[r*4 + 2];
      endcase
      ev            = e[W-1:0];
      nxt[0].neg[r] = ev[W-1];
      nxt[0].mag[r] = ev[W-1] ? W'(-ev) : W'(ev);
    end
    case (ccnt)
      2'd0:    e = mat[3];
      2'd1:    e = mat[7];
      default: e = mat[11];
    endcase
    tv           = e[W-1:0];
    nxt[0].trans = asrs_pkg::FIELD_W'(tv);
  end

  // Squares of the three magnitudes
  always_comb begin
    nxt[K_SQ] = st[K_SQ-1];
    for (int r = 0; r < 3; r++) begin
      nxt[K_SQ].sq[r] = st[K_SQ-1].mag[r] * st[K_SQ-1].mag[r];
    end
  end

  // Sum of squares, root state cleared
  always_comb begin
    nxt[K_SUM]      = st[K_SUM-1];
    nxt[K_SUM].rad  = st[K_SUM-1].sq[0] + st[K_SUM-1].sq[1] + st[K_SUM-1].sq[2];
    nxt[K_SUM].srem = '0;
    nxt[K_SUM].root = '0;
  end

  // Square root, one result bit per stage
  for (genvar k = K_RT0; k < K_DV0; k++) begin : g_root
    logic [W+2:0] cat;
    logic [W+2:0] trial;
    always_comb begin
      nxt[k]     = st[k-1];
      cat        = {st[k-1].srem[W:0], st[k-1].rad[SQ_W-1 -: 2]};
      trial      = {1'b0, st[k-1].root, 2'b01};
      nxt[k].rad = st[k-1].rad << 2;
      if (cat >= trial) begin
        nxt[k].srem = (W+2)'(cat - trial);
        nxt[k].root = {st[k-1].root[W-2:0], 1'b1};
      end else begin
        nxt[k].srem = cat[W+1:0];
        nxt[k].root = {st[k-1].root[W-2:0], 1'b0};
      end
    end
  end

  // Restoring divide of (magnitude << FRAC_BITS) by the root, three lanes,
  // one quotient bit per stage. The quotient never exceeds one.
  for (genvar k = K_DV0; k < NSTG; k++) begin : g_div
    localparam bit FIRST = (k == K_DV0);
    logic [2:0][W-1:0] base;
    logic [2:0]        nbit;
    logic [2:0][W:0]   cat;
    always_comb begin
      nxt[k] = st[k-1];
      for (int r = 0; r < 3; r++) begin
        base[r] = FIRST ? {1'b0, st[k-1].mag[r][W-1:1]} : st[k-1].drem[r];
        nbit[r] = FIRST ? st[k-1].mag[r][0] : 1'b0;
        cat[r]  = {base[r], nbit[r]};
        if (cat[r] >= {1'b0, st[k-1].root}) begin
          nxt[k].drem[r] = W'(cat[r] - {1'b0, st[k-1].root});
          nxt[k].quo[r]  = {st[k-1].quo[r][QW-2:0], 1'b1};
        end else begin
          nxt[k].drem[r] = cat[r][W-1:0];
          nxt[k].quo[r]  = {st[k-1].quo[r][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], busy};
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Output formatting from the last stage
  logic [asrs_pkg::FIELD_W-1:0]     root32;
  logic [asrs_pkg::SCALE_W-1:0]     scale;
  logic [2:0][asrs_pkg::ROT_W-1:0]  rot;
  logic                             zero;

  always_comb begin
    logic [31:0] v;
    root32 = asrs_pkg::FIELD_W'(st[LST].root);
    scale  = root32[31] ? '1 : root32[asrs_pkg::SCALE_W-1:0];
    zero   = (st[LST].root == '0);
    for (int r = 0; r < 3; r++) begin
      if (zero) begin
        v = (st[LST].col == asrs_pkg::COL_W'(r)) ? (32'd1 << FRAC_BITS) : 32'd0;
      end else if (st[LST].neg[r]) begin
        v = 32'd0 - 32'(st[LST].quo[r]);
      end else begin
        v = 32'(st[LST].quo[r]);
      end
      rot[r] = v[asrs_pkg::ROT_W-1:0];
    end
  end

  assign m_tvalid = vld[LST];
  assign m_tlast  = st[LST].last;
  assign m_tdata  = {1'b0, st[LST].trans, rot[2], rot[1], rot[0], scale, st[LST].col};

endmodule
`default_nettype wire

// ===== hdl/asrs_check.sv =====
// Port-level checker for the affine scale / rotation split block, with its bind.
`default_nettype none
module asrs_check (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [asrs_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tlast
);

  logic [asrs_pkg::COL_W-1:0] exp_col;

  // Track which column the next result request must carry.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_col <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_col <= m_tlast ? '0 : exp_col + 1'b1;
    end
  end

  a_col_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] == exp_col)
    else $error("result column out of order");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == (m_tdata[1:0] == asrs_pkg::LAST_COL))
    else $error("tlast not on column 2");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[asrs_pkg::M_TDATA_W-1] == 1'b0)
    else $error("padding bit set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // A matrix occupies the serializer for three columns, so no request right after one.
  a_in_spacing: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

endmodule

bind affine_scale_rotation_split asrs_check u_asrs_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the affine scale / rotation split block: random and directed matrices.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asrs_pkg::*;

  localparam int ONE = 1 << 16;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [SCALE_W-1:0] col_scale;
    logic [ROT_W-1:0]   rot_r0;
    logic [ROT_W-1:0]   rot_r1;
    logic [ROT_W-1:0]   rot_r2;
    logic [FIELD_W-1:0] trans_part;
    logic               last;
  } split_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  logic [S_TDATA_W-1:0] matrix_q[$];
  split_t split_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  affine_scale_rotation_split dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, floor, bit by bit.
  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Push the three column results expected for one matrix.
  task automatic predict_split(input logic [S_TDATA_W-1:0] mat);
    logic signed [31:0] e[3][4];
    logic [63:0] sum, rt, mag, q;
    logic [ROT_W-1:0] rot[3];
    split_t s;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) e[r][c] = mat[(r*4+c)*32 +: 32];
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int r = 0; r < 3; r++) begin
        mag = e[r][c] < 0 ? 64'(-64'(e[r][c])) : 64'(e[r][c]);
        sum = sum + mag * mag;
      end
      rt = root64(sum);
      for (int r = 0; r < 3; r++) begin
        if (rt == 0) begin
          rot[r] = (r == c) ? ROT_W'(ONE) : '0;
        end else begin
          mag = e[r][c] < 0 ? 64'(-64'(e[r][c])) : 64'(e[r][c]);
          q = (mag << 16) / rt;
          if (q > ONE) q = ONE;
          rot[r] = e[r][c] < 0 ? ROT_W'(-q) : ROT_W'(q);
        end
      end
      s.column = COL_W'(c);
      s.col_scale = rt > 64'h7FFFFFFF ? 31'h7FFFFFFF : rt[30:0];
      s.rot_r0 = rot[0];
      s.rot_r1 = rot[1];
      s.rot_r2 = rot[2];
      s.trans_part = e[c][3];
      s.last = (COL_W'(c) == LAST_COL);
      split_q.push_back(s);
    end
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'd0;
      3: return $urandom_range(0, 2*ONE) - ONE;
      4: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: present the next matrix after a random gap, advance on accept.
  always @(posedge clk) begin
    int g;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_split(s_tdata);
        g = $urandom_range(0, 10) * $urandom_range(0, 1);
        if (g == 0 && matrix_q.size() > 0) begin
          s_tdata <= matrix_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
          send_gap <= g;
        end
      end else if (!s_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (matrix_q.size() > 0) begin
          s_tdata <= matrix_q.pop_front();
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: stall at random, check each accepted result against the oldest one.
  always @(posedge clk) begin
    split_t got, want;
    int g;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.column = m_tdata[1:0];
        got.col_scale = m_tdata[32:2];
        got.rot_r0 = m_tdata[50:33];
        got.rot_r1 = m_tdata[68:51];
        got.rot_r2 = m_tdata[86:69];
        got.trans_part = m_tdata[118:87];
        got.last = m_tlast;
        if (split_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %p", got);
        end else begin
          want = split_q.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10) $display("expected %p, got %p", want, got);
          end
        end
        g = $urandom_range(0, 10) * $urandom_range(0, 1);
        if (g > 0) begin
          m_tready <= 1'b0;
          recv_gap <= g - 1;
        end
      end else if (!m_tready) begin
        if (recv_gap > 0) begin
          recv_gap <= recv_gap - 1;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic [S_TDATA_W-1:0] mat;
    // Directed: zeros, identity, extremes, single zero columns, small values.
    matrix_q.push_back('0);
    mat = '0;
    for (int i = 0; i < 3; i++) mat[(i*4+i)*32 +: 32] = ONE;
    matrix_q.push_back(mat);
    matrix_q.push_back({12{32'h80000000}});
    matrix_q.push_back({12{32'h7FFFFFFF}});
    matrix_q.push_back({12{32'hFFFFFFFF}});
    matrix_q.push_back({12{32'h00000001}});
    matrix_q.push_back({6{32'h80000000, 32'h7FFFFFFF}});
    matrix_q.push_back({6{32'h55555555, 32'hAAAAAAAA}});
    for (int z = 0; z < 3; z++) begin
      mat = '0;
      for (int k = 0; k < 12; k++) mat[k*32 +: 32] = rand_entry();
      for (int r = 0; r < 3; r++) mat[(r*4+z)*32 +: 32] = '0;
      matrix_q.push_back(mat);
    end
    for (int k = 0; k < 12; k++) begin
      mat = '0;
      mat[k*32 +: 32] = 32'h80000000;
      matrix_q.push_back(mat);
    end
    for (int n = 0; n < 207; n++) begin
      for (int k = 0; k < 12; k++) mat[k*32 +: 32] = rand_entry();
      if ($urandom_range(0, 5) == 0)
        for (int r = 0; r < 3; r++) mat[(r*4+n%3)*32 +: 32] = '0;
      matrix_q.push_back(mat);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (matrix_q.size() == 0 && !s_tvalid);
    wait (split_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && split_q.size() == 0) begin
      $display("affine_scale_rotation_split: match");
    end else begin
      $display("affine_scale_rotation_split: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("affine_scale_rotation_split: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
